FILE: rtl/core/md5_pkg.sv
// Shared types, round constants and schedule helpers of the MD5 engine.
package md5_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,    // takes message words
        ST_ROUND,   // one MD5 round per cycle
        ST_ADD,     // fold working words into chaining words
        ST_PAD,     // 0x80 marker, zero fill, optional length
        ST_SECOND,  // extra padding block: zeros and length
        ST_EMIT     // load digest into the output register
    } t_state;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    localparam int unsigned NUM_ROUNDS = 64;
    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned BLOCK_WORDS = 16;

    localparam logic [7:0] PAD_MARKER = 8'h80;
    localparam logic [5:0] LAST_POS   = 6'h3f;
    localparam logic [5:0] LEN_POS    = 6'd56;   // first byte of the length field

    localparam logic [31:0] ROUND_K [NUM_ROUNDS] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROUND_S [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // message word index for a round; the top two round bits pick the formula, the low four feed it
    function automatic logic [3:0] msg_index(input logic [5:0] rnd);
        logic [3:0] r4;
        logic [3:0] idx;
        r4 = rnd[3:0];
        case (rnd[5:4])
            2'd0:    idx = r4;
            2'd1:    idx = 4'((r4 << 2) + r4 + 4'd1);
            2'd2:    idx = 4'((r4 << 1) + r4 + 4'd5);
            default: idx = 4'((r4 << 3) - r4);
        endcase
        return idx;
    endfunction

    function automatic logic [31:0] round_func(input logic [1:0] phase,
                                               input logic [31:0] b,
                                               input logic [31:0] c,
                                               input logic [31:0] d);
        logic [31:0] f;
        case (phase)
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (b & d) | (c & ~d);
            2'd2:    f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
        return f;
    endfunction

endpackage

FILE: rtl/core/md5_hash_engine.sv
// MD5 engine: byte intake, padding sequencer and one shared round unit.
// A last word that leaves room for the length runs ST_PAD, the rounds, ST_ADD and ST_EMIT
//   before o_out_valid rises; one that fills a block is compressed first and then padded
//   in a further block, and one that needs an extra padding block adds a compression from ST_SECOND.
// Throughput: one byte per cycle into the block buffer while o_in_stall is low; the 64th byte
//   of a block starts 64 rounds through the single round unit, one fold and a return to idle.
// Reset (i_rst_n low, synchronous): chaining words to the MD5 initial values, bit
//   count to zero, sequencer idle, output empty; the block buffer is not cleared.
module md5_hash_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // message byte channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_last,
    // digest channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_digest_low,
    output logic [63:0] o_digest_high
);

    md5_pkg::t_state r_state, n_state;

    logic [5:0]  r_round, n_round;        // round index inside ST_ROUND
    logic [63:0] r_bit_count, n_bit_count;
    logic [31:0] r_chain [4];
    logic [31:0] n_chain [4];
    logic [31:0] r_buf [md5_pkg::BLOCK_WORDS];  // block buffer, byte 4j in bits 7..0
    logic [31:0] n_buf [md5_pkg::BLOCK_WORDS];
    logic [31:0] r_a, r_b, r_c, r_d;      // working words
    logic [31:0] n_a, n_b, n_c, n_d;

    // sequencing flags for the tail of a message
    logic r_pad_pending, n_pad_pending;   // last item filled a block: pad after it
    logic r_second, n_second;             // padding spills into one more block
    logic r_finish, n_finish;             // digest is ready after this compression

    logic        r_out_valid, n_out_valid;
    logic [63:0] r_digest_low, r_digest_high;

    logic        w_accept;
    logic        w_emit;
    logic [5:0]  w_pos;                   // buffer byte position = bit_count[8:3]
    logic [1:0]  w_phase;
    logic [3:0]  w_g;
    logic [4:0]  w_shift;
    logic [31:0] w_f;
    logic [31:0] w_sum;
    logic [63:0] w_rot_wide;

    assign o_in_stall = (r_state != md5_pkg::ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_pos      = r_bit_count[8:3];
    assign w_emit     = (r_state == md5_pkg::ST_EMIT) && (!r_out_valid || !i_out_stall);

    // ---------------------------------------------------------------------
    // Shared round unit: F, message word, constant, rotate, add.
    // ---------------------------------------------------------------------
    assign w_phase    = r_round[5:4];
    assign w_g        = md5_pkg::msg_index(r_round);
    assign w_shift    = md5_pkg::ROUND_S[{w_phase, r_round[1:0]}];
    assign w_f        = md5_pkg::round_func(w_phase, r_b, r_c, r_d);
    assign w_sum      = r_a + w_f + md5_pkg::ROUND_K[r_round] + r_buf[w_g];
    assign w_rot_wide = {w_sum, w_sum} << w_shift;  // upper half is the left rotate

    // ---------------------------------------------------------------------
    // Sequencer: next state, datapath updates
    // ---------------------------------------------------------------------
    always_comb begin
        n_state       = r_state;
        n_round       = r_round;
        n_bit_count   = r_bit_count;
        n_chain       = r_chain;
        n_buf         = r_buf;
        n_a           = r_a;
        n_b           = r_b;
        n_c           = r_c;
        n_d           = r_d;
        n_pad_pending = r_pad_pending;
        n_second      = r_second;
        n_finish      = r_finish;
        n_out_valid   = r_out_valid && i_out_stall;

        case (r_state)
            md5_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (i_byte_present) begin
                        n_buf[w_pos[5:2]][{w_pos[1:0], 3'b000} +: 8] = i_data_byte;
                        n_bit_count = r_bit_count + 64'd8;
                    end
                    if (i_byte_present && (w_pos == md5_pkg::LAST_POS)) begin
                        // block full: compress now, pad afterwards if this ends it
                        n_pad_pending = i_last;
                        n_a     = r_chain[0];
                        n_b     = r_chain[1];
                        n_c     = r_chain[2];
                        n_d     = r_chain[3];
                        n_state = md5_pkg::ST_ROUND;
                    end else if (i_last) begin
                        n_state = md5_pkg::ST_PAD;
                    end
                end
            end

            md5_pkg::ST_PAD: begin
                // marker at the current position, zeros above it
                for (int j = 0; j < md5_pkg::BLOCK_WORDS; j++) begin
                    for (int k = 0; k < 4; k++) begin
                        if (6'(j * 4 + k) == w_pos) begin
                            n_buf[j][k*8 +: 8] = md5_pkg::PAD_MARKER;
                        end else if (6'(j * 4 + k) > w_pos) begin
                            n_buf[j][k*8 +: 8] = 8'h00;
                        end
                    end
                end
                if (w_pos < md5_pkg::LEN_POS) begin
                    n_buf[md5_pkg::BLOCK_WORDS-2] = r_bit_count[31:0];
                    n_buf[md5_pkg::BLOCK_WORDS-1] = r_bit_count[63:32];
                    n_finish = 1'b1;
                end else begin
                    n_second = 1'b1;
                end
                n_a     = r_chain[0];
                n_b     = r_chain[1];
                n_c     = r_chain[2];
                n_d     = r_chain[3];
                n_state = md5_pkg::ST_ROUND;
            end

            md5_pkg::ST_SECOND: begin
                for (int j = 0; j < md5_pkg::BLOCK_WORDS - 2; j++) begin
                    n_buf[j] = 32'h0;
                end
                n_buf[md5_pkg::BLOCK_WORDS-2] = r_bit_count[31:0];
                n_buf[md5_pkg::BLOCK_WORDS-1] = r_bit_count[63:32];
                n_second = 1'b0;
                n_finish = 1'b1;
                n_a      = r_chain[0];
                n_b      = r_chain[1];
                n_c      = r_chain[2];
                n_d      = r_chain[3];
                n_state  = md5_pkg::ST_ROUND;
            end

            md5_pkg::ST_ROUND: begin
                n_a = r_d;
                n_d = r_c;
                n_c = r_b;
                n_b = r_b + w_rot_wide[63:32];
                n_round = r_round + 6'd1;
                if (r_round == 6'(md5_pkg::NUM_ROUNDS - 1)) begin
                    n_state = md5_pkg::ST_ADD;
                end
            end

            md5_pkg::ST_ADD: begin
                n_chain[0] = r_chain[0] + r_a;
                n_chain[1] = r_chain[1] + r_b;
                n_chain[2] = r_chain[2] + r_c;
                n_chain[3] = r_chain[3] + r_d;
                if (r_pad_pending) begin
                    n_pad_pending = 1'b0;
                    n_state       = md5_pkg::ST_PAD;
                end else if (r_second) begin
                    n_state = md5_pkg::ST_SECOND;
                end else if (r_finish) begin
                    n_state = md5_pkg::ST_EMIT;
                end else begin
                    n_state = md5_pkg::ST_IDLE;
                end
            end

            md5_pkg::ST_EMIT: begin
                // wait for the output register, then restart the hash
                if (w_emit) begin
                    n_out_valid = 1'b1;
                    n_finish    = 1'b0;
                    n_chain[0]  = md5_pkg::INIT_A;
                    n_chain[1]  = md5_pkg::INIT_B;
                    n_chain[2]  = md5_pkg::INIT_C;
                    n_chain[3]  = md5_pkg::INIT_D;
                    n_bit_count = 64'd0;
                    n_state     = md5_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = md5_pkg::ST_IDLE;
            end
        endcase
    end

    // control and hash state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= md5_pkg::ST_IDLE;
            r_round       <= 6'd0;
            r_bit_count   <= 64'd0;
            r_chain[0]    <= md5_pkg::INIT_A;
            r_chain[1]    <= md5_pkg::INIT_B;
            r_chain[2]    <= md5_pkg::INIT_C;
            r_chain[3]    <= md5_pkg::INIT_D;
            r_pad_pending <= 1'b0;
            r_second      <= 1'b0;
            r_finish      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_round       <= n_round;
            r_bit_count   <= n_bit_count;
            r_chain       <= n_chain;
            r_pad_pending <= n_pad_pending;
            r_second      <= n_second;
            r_finish      <= n_finish;
            r_out_valid   <= n_out_valid;
        end
    end

    // payload: block buffer, working words, digest
    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
        r_a   <= n_a;
        r_b   <= n_b;
        r_c   <= n_c;
        r_d   <= n_d;
        if (w_emit) begin
            r_digest_low  <= {r_chain[1], r_chain[0]};
            r_digest_high <= {r_chain[3], r_chain[2]};
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_digest_low  = r_digest_low;
    assign o_digest_high = r_digest_high;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_round_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != md5_pkg::ST_ROUND) |-> (r_round == 6'd0))
        else $error("round counter left nonzero outside the round loop");

    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_last) |=> (r_state != md5_pkg::ST_IDLE))
        else $error("last word accepted without padding sequence");

    a_tail_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_second && r_finish))
        else $error("extra padding block and digest both pending");

    a_pad_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pad_pending |-> (r_state == md5_pkg::ST_ROUND || r_state == md5_pkg::ST_ADD))
        else $error("pad request outstanding outside a compression");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (r_bit_count == 64'd0 && r_chain[0] == md5_pkg::INIT_A
                    && o_out_valid))
        else $error("digest emitted without restarting the hash");

endmodule

FILE: sim/tb_md5_hash_engine.sv
// Testbench of md5_hash_engine: random byte messages checked against a behavioral MD5.
`timescale 1ns / 1ps

module tb_md5_hash_engine;

    // Expected digest as it shows on the two output ports.
    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
    } t_digest;

    // ------------------------------------------------------------------
    // Clock, reset and the ports of the block
    // ------------------------------------------------------------------
    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte    = 8'h00;
    logic        byte_present = 1'b0;
    logic        msg_last     = 1'b0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [63:0] digest_low;
    logic [63:0] digest_high;

    // Idle rates in percent: chance that the sender holds back a word,
    // and chance that the receiver stalls in a given cycle.
    int unsigned snd_idle_pct = 9;
    int unsigned rcv_idle_pct = 88;

    int unsigned err_count  = 0;
    int unsigned words_sent = 0;   // words that carry a byte or end a message
    int unsigned msgs_sent  = 0;

    // Digests still owed by the block, oldest first.
    t_digest digest_q [$];
    t_digest want_digest;

    // ------------------------------------------------------------------
    // Behavioral MD5: chaining words, running bit count, block buffer
    // ------------------------------------------------------------------
    logic [31:0] hash_word [0:3];
    logic [63:0] msg_bits;
    logic [7:0]  blk [0:63];

    // Additive constants, one per round.
    logic [31:0] sine_k [0:63] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Left-rotate amounts: four per group of sixteen rounds.
    int rot_amt [0:15] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

    // Message lengths that sit on either side of a padding decision or a block edge.
    int boundary_len [0:11] = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

    md5_hash_engine u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_data_byte    (data_byte),
        .i_byte_present (byte_present),
        .i_last         (msg_last),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_digest_low   (digest_low),
        .o_digest_high  (digest_high)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Back to the initial chaining values with an empty message.
    function automatic void md5_restart();
        hash_word[0] = 32'h67452301;
        hash_word[1] = 32'hefcdab89;
        hash_word[2] = 32'h98badcfe;
        hash_word[3] = 32'h10325476;
        msg_bits     = 64'd0;
    endfunction

    // 64 rounds over the current block, folded into the chaining words.
    function automatic void md5_compress();
        logic [31:0] w [0:15];
        logic [31:0] a, b, c, d, f, t;
        int          r, g, ph, s;
        for (r = 0; r < 16; r++) begin
            w[r] = {blk[4*r+3], blk[4*r+2], blk[4*r+1], blk[4*r]};
        end
        a = hash_word[0];
        b = hash_word[1];
        c = hash_word[2];
        d = hash_word[3];
        for (r = 0; r < 64; r++) begin
            ph = r / 16;
            case (ph)
                0: begin
                    f = (b & c) | (~b & d);
                    g = r;
                end
                1: begin
                    f = (b & d) | (c & ~d);
                    g = (5 * r + 1) % 16;
                end
                2: begin
                    f = b ^ c ^ d;
                    g = (3 * r + 5) % 16;
                end
                default: begin
                    f = c ^ (b | ~d);
                    g = (7 * r) % 16;
                end
            endcase
            t = a + f + sine_k[r] + w[g];
            s = rot_amt[ph * 4 + r % 4];
            a = d;
            d = c;
            c = b;
            b = b + ((t << s) | (t >> (32 - s)));
        end
        hash_word[0] += a;
        hash_word[1] += b;
        hash_word[2] += c;
        hash_word[3] += d;
    endfunction

    // Applies one accepted word; a word that ends the message queues its digest.
    function automatic void md5_take_word(input logic [7:0] b, input logic present,
                                          input logic fin);
        logic [5:0] pos;
        t_digest    d;
        int         k;
        if (present) begin
            pos      = msg_bits[8:3];
            blk[pos] = b;
            msg_bits = msg_bits + 64'd8;
            if (pos == 6'd63) begin
                md5_compress();
            end
        end
        if (fin) begin
            // marker byte, zero fill, and a second block when the length won't fit
            pos      = msg_bits[8:3];
            blk[pos] = 8'h80;
            for (k = int'(pos) + 1; k < 64; k++) begin
                blk[k] = 8'h00;
            end
            if (pos >= 6'd56) begin
                md5_compress();
                for (k = 0; k < 56; k++) begin
                    blk[k] = 8'h00;
                end
            end
            for (k = 0; k < 8; k++) begin
                blk[56+k] = msg_bits[8*k +: 8];
            end
            md5_compress();
            d.lo = {hash_word[1], hash_word[0]};
            d.hi = {hash_word[3], hash_word[2]};
            digest_q = {digest_q, d};
            md5_restart();
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] MISMATCH %s: got %h want %h", $realtime, what, got, want);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // Sender: entered and left at a falling edge. Idle cycles drop valid and
    // put junk on the payload; once valid is up it stays until the word goes.
    // ------------------------------------------------------------------
    task automatic send_word(input logic [7:0] b, input logic present, input logic fin);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            in_valid     <= 1'b0;
            data_byte    <= 8'($urandom_range(0, 255));
            byte_present <= 1'($urandom_range(0, 1));
            msg_last     <= 1'($urandom_range(0, 1));
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        data_byte    <= b;
        byte_present <= present;
        msg_last     <= fin;
        do @(posedge clk); while (in_stall !== 1'b0);
        md5_take_word(b, present, fin);
        if (present | fin) begin
            words_sent++;
        end
        if (fin) begin
            msgs_sent++;
        end
        @(negedge clk);
    endtask

    // One message of len bytes with random content and a sprinkling of empty
    // words. It ends either on its last byte or on a separate word with no byte.
    task automatic send_message(input int len);
        logic end_on_byte;
        int   i;
        end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
        for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            send_word(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (i == len - 1));
        end
        if (!end_on_byte) begin
            send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
    endtask

    // Receiver stall, redrawn every cycle.
    always @(negedge clk) begin
        out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Digest checker: every digest taken is held against the oldest one owed.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
            if (digest_q.size() == 0) begin
                report_mismatch("digest with none owed", digest_low, 64'd0);
            end else begin
                want_digest = digest_q.pop_front();
                if (digest_low !== want_digest.lo) begin
                    report_mismatch("digest_low", digest_low, want_digest.lo);
                end
                if (digest_high !== want_digest.hi) begin
                    report_mismatch("digest_high", digest_high, want_digest.hi);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked messages: empty, a lone byte on the closing word, extreme
    // byte values, a closing word with no byte, empty words inside a message.
    task automatic test_edge_messages();
        send_word(8'h5a, 1'b0, 1'b1);   // nothing but the end flag: empty message
        send_word(8'h00, 1'b1, 1'b1);   // single zero byte, closed on the same word
        send_word(8'hff, 1'b1, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);   // single 0xff, closed by an empty word
        send_word(8'ha5, 1'b0, 1'b0);   // ignored word before a message
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'hff, 1'b0, 1'b0);   // ignored word mid-message
        send_word(8'h63, 1'b1, 1'b1);
        send_word(8'h80, 1'b1, 1'b0);
        send_word(8'h7f, 1'b1, 1'b0);
        send_word(8'h01, 1'b1, 1'b0);
        send_word(8'hfe, 1'b1, 1'b1);
        send_word(8'h3c, 1'b0, 1'b1);   // another empty message right after
    endtask

    // Random messages until enough words and digests have gone through.
    // A quarter of them land on a padding or block edge; the rest stay short.
    task automatic test_random_messages(input int unsigned snd_pct,
                                        input int unsigned rcv_pct);
        int unsigned words_goal;
        int unsigned msgs_goal;
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        words_goal   = words_sent + 350;
        msgs_goal    = msgs_sent + 10;
        while (words_sent < words_goal || msgs_sent < msgs_goal) begin
            if ($urandom_range(0, 3) == 0) begin
                send_message(boundary_len[$urandom_range(0, 11)]);
            end else begin
                send_message($urandom_range(0, 40));
            end
        end
    endtask

    // Drain the digests still owed, then allow a worst-case latency for any
    // stray output before the verdict.
    task automatic finish_run();
        in_valid <= 1'b0;
        while (digest_q.size() != 0) @(posedge clk);
        repeat (150) @(posedge clk);
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    endtask

    initial begin
        md5_restart();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_edge_messages();
        test_random_messages(9, 88);
        test_random_messages(88, 9);
        test_random_messages(0, 0);
        finish_run();
    end

    // Hang guard: far beyond the slowest legal run.
    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/md5_pkg.sv
rtl/core/md5_hash_engine.sv
sim/tb_md5_hash_engine.sv
